// ===== design/mppt_pkg.sv =====
`timescale 1ns / 1ps

package mppt_pkg;

  localparam int CH_N     = 4;
  localparam int CH_W     = $clog2(CH_N);
  localparam int WIN_LEN  = 256;
  localparam int WIN_AW   = $clog2(WIN_LEN);

  localparam int SAMPLE_W = 16;
  localparam int OS_SHIFT = 12;
  localparam int OFS_W    = 32;
  localparam int NOISE_W  = 59;
  localparam int POW_W    = 64;
  localparam int CNT_W    = 48;

  // exact difference of shifted sample and offset, and its magnitude
  localparam int SHIFTED_W = SAMPLE_W + OS_SHIFT;
  localparam int DIFF_W    = ((SHIFTED_W > OFS_W) ? SHIFTED_W : OFS_W) + 1;
  localparam int MAG_W     = DIFF_W - 1;

  localparam int HOLDON_SAMPLES  = 128;
  localparam int HOLDON_W        = 8;
  localparam int HOLDOFF_SAMPLES = 100000;
  localparam int HOLDOFF_W       = 17;
  localparam int TRIG_FACTOR     = 20;

  // configuration register map
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = NOISE_W;
  localparam int REG_OFS_BASE   = 0;
  localparam int REG_NOISE_BASE = REG_OFS_BASE + CH_N;
  localparam int REG_END        = REG_NOISE_BASE + CH_N;

  // result queue, power of two deep
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [OFS_W-1:0]    ofs_t;
  typedef logic [NOISE_W-1:0]         noise_t;
  typedef logic [POW_W-1:0]           pow_t;

  localparam ofs_t OFS_RESET [CH_N] = '{
    -32'sd2050396, -32'sd3332515, -32'sd3119739, -32'sd7971855
  };
  localparam noise_t NOISE_RESET [CH_N] = '{
    59'd8515658300000, 59'd7120073000000, 59'd7000765000000, 59'd9395975000000
  };

  typedef struct packed {
    logic valid;
    logic above;
  } pwr_status_t;

  typedef struct packed {
    logic             ping_fired;
    logic             holding_off;
    logic [CNT_W-1:0] sample_number;
  } result_t;

endpackage

// ===== design/mppt_sample_if.sv =====
`timescale 1ns / 1ps

interface mppt_sample_if import mppt_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_ch0;
  sample_t sample_ch1;
  sample_t sample_ch2;
  sample_t sample_ch3;

  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                output ready);
endinterface

// ===== design/mppt_result_if.sv =====
`timescale 1ns / 1ps

interface mppt_result_if import mppt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ping_fired;
  logic             holding_off;
  logic [CNT_W-1:0] sample_number;

  modport source (output valid, ping_fired, holding_off, sample_number, input ready);
  modport sink (input valid, ping_fired, holding_off, sample_number, output ready);
endinterface

// ===== design/multichannel_ping_power_trigger_top.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Handshake      Payload
// in_item    in   valid/ready    sample_ch0..3 (16-bit signed each)
// out_item   out  valid/ready    ping_fired, holding_off, sample_number[47:0]
// cfg_*      in   cfg_we only    cfg_index[3:0], cfg_data[58:0]
//
// One item per cycle sustained while in_item.ready is high; each accepted
// item's result passes ring read, magnitude, square, ring write / delta,
// running sum, threshold compare and trigger update, then the result queue.
// Synchronous active-low reset. The square ring is not cleared: during the
// first lap after reset its reads are forced to zero, so no clearing pass.
// in_item.ready drops only when eight items are in flight or queued, i.e.
// when out_item has been stalled long enough to fill the result queue.

module multichannel_ping_power_trigger_top import mppt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mppt_sample_if.sink           in_item,
  mppt_result_if.source         out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ofs_t             offset_r [CH_N];
  // threshold kept premultiplied: twenty times the noise power
  pow_t             thr_r [CH_N];
  sample_t          sample [CH_N];
  logic             accept;
  logic             credit;
  logic [CFG_IDX_W-1:0] noise_sel;
  pwr_status_t      status;
  logic             res_valid;
  result_t          res;

  assign in_item.ready = credit;
  assign accept        = in_item.valid && in_item.ready;

  assign sample[0] = in_item.sample_ch0;
  assign sample[1] = in_item.sample_ch1;
  assign sample[2] = in_item.sample_ch2;
  assign sample[3] = in_item.sample_ch3;

  assign noise_sel = cfg_index - CFG_IDX_W'(REG_NOISE_BASE);

  // register file; writes beyond the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CH_N; c++) begin
        offset_r[c] <= OFS_RESET[c];
        thr_r[c]    <= POW_W'(NOISE_RESET[c]) * POW_W'(TRIG_FACTOR);
      end
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_W'(REG_NOISE_BASE)) begin
        offset_r[cfg_index[CH_W-1:0]] <= cfg_data[OFS_W-1:0];
      end else if (cfg_index < CFG_IDX_W'(REG_END)) begin
        thr_r[noise_sel[CH_W-1:0]] <= POW_W'(cfg_data[NOISE_W-1:0]) * POW_W'(TRIG_FACTOR);
      end
    end
  end

  mppt_power_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sample (sample),
    .offset (offset_r),
    .thr    (thr_r),
    .status (status)
  );

  mppt_trigger_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .status    (status),
    .res_valid (res_valid),
    .res       (res)
  );

  mppt_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .push      (res_valid),
    .push_data (res),
    .credit    (credit),
    .out_item  (out_item)
  );

endmodule

// ===== design/mppt_ring_mem.sv =====
`timescale 1ns / 1ps

module mppt_ring_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/mppt_power_pipe.sv =====
`timescale 1ns / 1ps

module mppt_power_pipe import mppt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  sample_t     sample [CH_N],
  input  ofs_t        offset [CH_N],
  input  pow_t        thr [CH_N],
  output pwr_status_t status
);

  typedef logic [CH_N-1:0][POW_W-1:0] row_t;

  // control
  logic              v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [WIN_AW-1:0] pos_r, pos_nxt;
  logic              lap_r;
  pow_t              wp_r [CH_N];

  // payload
  logic signed [DIFF_W-1:0] diff1_r [CH_N];
  logic signed [DIFF_W-1:0] diff_nxt [CH_N];
  logic [MAG_W-1:0]         mag2_r [CH_N];
  logic [2*MAG_W-1:0]       sq_nxt [CH_N];
  row_t                     sq3_r;
  pow_t                     old2_r [CH_N];
  pow_t                     old3_r [CH_N];
  pow_t                     delta4_r [CH_N];
  logic [WIN_AW-1:0]        pos1_r, pos2_r, pos3_r;
  logic                     lap1_r;
  row_t                     rd_row;
  logic [CH_N-1:0]          ge;

  assign pos_nxt = (pos_r == WIN_AW'(WIN_LEN - 1)) ? '0 : pos_r + 1'b1;

  // old squares read at accept, new squares written once the item reaches the square
  // stage (v3_r); the same entry comes back only a full window later
  mppt_ring_mem #(
    .DEPTH (WIN_LEN),
    .WIDTH (CH_N * POW_W)
  ) u_ring (
    .clk   (clk),
    .we    (v3_r),
    .waddr (pos3_r),
    .wdata (sq3_r),
    .re    (accept),
    .raddr (pos_r),
    .rdata (rd_row)
  );

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      diff_nxt[c] = (DIFF_W'(sample[c]) <<< OS_SHIFT) - DIFF_W'(offset[c]);
      sq_nxt[c]   = mag2_r[c] * mag2_r[c];
      ge[c]       = wp_r[c] >= thr[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      pos_r <= '0;
      lap_r <= 1'b0;
      for (int c = 0; c < CH_N; c++) begin
        wp_r[c] <= '0;
      end
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (accept) begin
        pos_r <= pos_nxt;
        if (pos_r == WIN_AW'(WIN_LEN - 1)) begin
          lap_r <= 1'b1;
        end
      end
      if (v4_r) begin
        for (int c = 0; c < CH_N; c++) begin
          wp_r[c] <= wp_r[c] + delta4_r[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pos1_r <= pos_r;
    lap1_r <= lap_r;
    pos2_r <= pos1_r;
    pos3_r <= pos2_r;
    for (int c = 0; c < CH_N; c++) begin
      diff1_r[c]  <= diff_nxt[c];
      mag2_r[c]   <= diff1_r[c][DIFF_W-1] ? MAG_W'(-diff1_r[c]) : MAG_W'(diff1_r[c]);
      // entries not yet written in the first lap read as zero
      old2_r[c]   <= lap1_r ? rd_row[c] : '0;
      sq3_r[c]    <= POW_W'(sq_nxt[c]);
      old3_r[c]   <= old2_r[c];
      delta4_r[c] <= sq3_r[c] - old3_r[c];
    end
  end

  assign status.valid = v5_r;
  assign status.above = &ge;

endmodule

// ===== design/mppt_trigger_ctrl.sv =====
`timescale 1ns / 1ps

module mppt_trigger_ctrl import mppt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pwr_status_t status,
  output logic        res_valid,
  output result_t     res
);

  logic [HOLDON_W-1:0]  holdon_r, holdon_nxt;
  logic [HOLDOFF_W-1:0] holdoff_r, holdoff_nxt;
  logic [CNT_W-1:0]     count_r;
  logic                 fire;

  always_comb begin
    holdon_nxt  = holdon_r;
    holdoff_nxt = holdoff_r;
    fire        = 1'b0;
    if (holdoff_r == '0) begin
      if (status.above) begin
        if (holdon_r < HOLDON_W'(HOLDON_SAMPLES)) begin
          holdon_nxt = holdon_r + 1'b1;
        end else begin
          fire        = 1'b1;
          holdoff_nxt = HOLDOFF_W'(HOLDOFF_SAMPLES);
          holdon_nxt  = '0;
        end
      end
    end else begin
      holdoff_nxt = holdoff_r - 1'b1;
      holdon_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdon_r  <= '0;
      holdoff_r <= '0;
      count_r   <= '0;
    end else if (status.valid) begin
      holdon_r  <= holdon_nxt;
      holdoff_r <= holdoff_nxt;
      count_r   <= count_r + 1'b1;
    end
  end

  assign res_valid         = status.valid;
  assign res.ping_fired    = fire;
  assign res.holding_off   = holdoff_r != '0;
  assign res.sample_number = count_r;

`ifndef SYNTHESIS
  a_fire_loads_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    (status.valid && fire) |=> (holdoff_r == HOLDOFF_W'(HOLDOFF_SAMPLES)))
    else $error("hold-off not loaded after ping");

  a_holdoff_clears_holdon: assert property (@(posedge clk) disable iff (!rst_n)
    (holdoff_r != '0) |-> (holdon_r == '0))
    else $error("hold-on counting during hold-off");
`endif

endmodule

// ===== design/mppt_out_fifo.sv =====
`timescale 1ns / 1ps

module mppt_out_fifo import mppt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept,
  input  logic  push,
  input  result_t push_data,
  output logic  credit,
  mppt_result_if.source out_item
);

  result_t             entry [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0]    cnt_r, occ_r;
  logic                pop;
  result_t             head;

  assign pop    = out_item.valid && out_item.ready;
  // occ_r counts items in the pipeline plus items queued here
  assign credit = occ_r != OCC_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      occ_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + OCC_W'(push) - OCC_W'(pop);
      occ_r <= occ_r + OCC_W'(accept) - OCC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr_r] <= push_data;
    end
  end

  assign head                   = entry[rd_ptr_r];
  assign out_item.valid         = cnt_r != '0;
  assign out_item.ping_fired    = head.ping_fired;
  assign out_item.holding_off   = head.holding_off;
  assign out_item.sample_number = head.sample_number;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != OCC_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= occ_r)
    else $error("queued items exceed items in flight");
`endif

endmodule

// ===== verif/multichannel_ping_power_trigger_top_tb.sv =====
`timescale 1ns / 1ps

module multichannel_ping_power_trigger_top_tb;
  import mppt_pkg::*;

  // one sample per channel, channel 0 in the low lane
  typedef logic [CH_N-1:0][SAMPLE_W-1:0] sample_set_t;
  // full register file image, index i holds register i
  typedef logic [REG_END-1:0][CFG_DATA_W-1:0] reg_image_t;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HALT, RX_TRICKLE} rx_mode_e;

  localparam sample_t TONE       = 16'sd10;       // 256 * (10 << 12)^2 = 100 << 32
  localparam noise_t  EDGE_NOISE = 59'd5 << 32;   // 20x this equals that window power
  localparam noise_t  NOISE_MAX  = '1;
  localparam ofs_t    OFS_MIN    = 32'sh8000_0000;
  localparam ofs_t    OFS_MAX    = 32'sh7FFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mppt_sample_if sample_bus ();
  mppt_result_if report_bus ();

  multichannel_ping_power_trigger_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (sample_bus),
    .out_item  (report_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Detector shadow: registers, square ring, running sums and trigger counters
  // ---------------------------------------------------------------------------
  ofs_t                ofs_reg   [CH_N];
  noise_t              noise_reg [CH_N];
  pow_t                sq_ring   [CH_N][WIN_LEN];
  pow_t                win_pow   [CH_N];
  logic [WIN_AW-1:0]   ring_pos;
  logic [HOLDON_W-1:0] holdon_cnt;
  logic [HOLDOFF_W-1:0] holdoff_left;
  logic [CNT_W-1:0]    sample_idx;

  result_t detector_reports [$];   // reports owed by the block, oldest first
  int      pings_fired;             // pings predicted so far
  int      mismatches;

  // traffic shaping
  bit       calm;                   // full rate on both sides
  int       burst_left;
  rx_mode_e rx_mode;
  int       rx_left;

  function automatic sample_set_t make_set(input sample_t s0, s1, s2, s3);
    sample_set_t set;
    set[0] = s0;
    set[1] = s1;
    set[2] = s2;
    set[3] = s3;
    return set;
  endfunction

  task automatic reset_detector_model();
    for (int c = 0; c < CH_N; c++) begin
      ofs_reg[c]   = OFS_RESET[c];
      noise_reg[c] = NOISE_RESET[c];
      win_pow[c]   = '0;
      for (int k = 0; k < WIN_LEN; k++) sq_ring[c][k] = '0;
    end
    ring_pos     = '0;
    holdon_cnt   = '0;
    holdoff_left = '0;
    sample_idx   = '0;
  endtask

  // Energy update for one accepted sample set, then the hold-on / hold-off
  // decision; queues the report the block owes for it.
  task automatic compute_detection(input sample_set_t set);
    logic signed [POW_W-1:0] sx, ox, d;
    pow_t    mag, sq, thr;
    logic    trig;
    result_t r;
    r.ping_fired    = 1'b0;
    r.holding_off   = (holdoff_left != 0);
    r.sample_number = sample_idx;
    for (int c = 0; c < CH_N; c++) begin
      sx  = $signed(set[c]);
      ox  = ofs_reg[c];
      d   = (sx <<< OS_SHIFT) - ox;    // exact, no 32-bit wrap
      mag = d[POW_W-1] ? pow_t'(-d) : pow_t'(d);
      sq  = mag * mag;
      win_pow[c] = win_pow[c] - sq_ring[c][ring_pos] + sq;   // mod 2^64
      sq_ring[c][ring_pos] = sq;
    end
    if (holdoff_left == 0) begin
      trig = 1'b1;
      for (int c = 0; c < CH_N; c++) begin
        thr = {{(POW_W-NOISE_W){1'b0}}, noise_reg[c]} * pow_t'(TRIG_FACTOR);
        if (win_pow[c] < thr) trig = 1'b0;
      end
      if (trig) begin
        if (holdon_cnt < HOLDON_SAMPLES) begin
          holdon_cnt++;
        end else begin
          r.ping_fired = 1'b1;
          holdoff_left = HOLDOFF_W'(HOLDOFF_SAMPLES);
          holdon_cnt   = '0;
          pings_fired++;
        end
      end
    end else begin
      holdoff_left--;
      holdon_cnt = '0;
    end
    ring_pos++;
    sample_idx++;
    detector_reports.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; called at a falling edge
  // and returns at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_sample_set(input sample_set_t set);
    int gap;
    if (!calm && burst_left == 0) begin
      sample_bus.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 32);
    end
    sample_bus.valid      <= 1'b1;
    sample_bus.sample_ch0 <= set[0];
    sample_bus.sample_ch1 <= set[1];
    sample_bus.sample_ch2 <= set[2];
    sample_bus.sample_ch3 <= set[3];
    do @(posedge clk); while (sample_bus.ready !== 1'b1);
    compute_detection(set);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  // Register writes happen only with the pipe empty.
  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data  <= data;
    @(negedge clk);
    if (idx < REG_NOISE_BASE) ofs_reg[idx - REG_OFS_BASE] = data[OFS_W-1:0];
    else if (idx < REG_END)   noise_reg[idx - REG_NOISE_BASE] = data;
    // unmapped indexes change nothing
  endtask

  task automatic load_image(input reg_image_t img);
    sample_bus.valid <= 1'b0;
    while (detector_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    for (int i = 0; i < REG_END; i++) write_reg(i, img[i]);
    // one stray write past the map, must be dropped
    write_reg(REG_END + $urandom_range(0, (1 << CFG_IDX_W) - 1 - REG_END),
              CFG_DATA_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
  endtask

  function automatic reg_image_t flat_image(input ofs_t ofs, input noise_t n0,
                                            input noise_t nrest);
    reg_image_t img;
    for (int c = 0; c < CH_N; c++) begin
      img[REG_OFS_BASE + c]   = {{(CFG_DATA_W-OFS_W){1'b0}}, ofs};
      img[REG_NOISE_BASE + c] = (c == 0) ? n0 : nrest;
    end
    return img;
  endfunction

  function automatic reg_image_t random_image();
    reg_image_t img;
    for (int c = 0; c < CH_N; c++) begin
      img[REG_OFS_BASE + c] = CFG_DATA_W'({$urandom, $urandom});   // junk above bit 31
      case ($urandom_range(0, 3))
        0: img[REG_OFS_BASE + c][OFS_W-1:0] = OFS_MIN;
        1: img[REG_OFS_BASE + c][OFS_W-1:0] = OFS_MAX;
        2: ;
        default: img[REG_OFS_BASE + c][OFS_W-1:0] = $urandom_range(0, 1 << 24) - (1 << 23);
      endcase
      case ($urandom_range(0, 3))
        0: img[REG_NOISE_BASE + c] = '0;
        1: img[REG_NOISE_BASE + c] = NOISE_MAX;
        2: img[REG_NOISE_BASE + c] = CFG_DATA_W'({$urandom, $urandom});
        default: img[REG_NOISE_BASE + c] = noise_t'($urandom) << $urandom_range(0, 26);
      endcase
    end
    return img;
  endfunction

  // Mostly signal at the phase amplitude, some full-scale noise and rail hits.
  function automatic sample_t random_sample(input int amp);
    sample_t v;
    case ($urandom_range(0, 9))
      7, 8: v = sample_t'($urandom);
      9: begin
        case ($urandom_range(0, 3))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end
      default: begin
        v = sample_t'($urandom_range(0, amp - 1));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver stall pattern and report checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (calm) begin
      report_bus.ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(4, 48);   // long halts back up the input
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:  report_bus.ready <= 1'b1;
        RX_COIN:  report_bus.ready <= 1'($urandom_range(0, 1));
        RX_HALT:  report_bus.ready <= 1'b0;
        default:  report_bus.ready <= (rx_left % 4 == 0);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] idx,
                                 input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    $display("mismatch at sample %0d: %s got %0h expected %0h", idx, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && report_bus.valid === 1'b1 && report_bus.ready === 1'b1) begin
      if (detector_reports.size() == 0) begin
        report_mismatch("report with no sample pending", report_bus.sample_number,
                        report_bus.sample_number, '0);
      end else begin
        want = detector_reports.pop_front();
        if (report_bus.ping_fired !== want.ping_fired)
          report_mismatch("ping_fired", want.sample_number,
                          CNT_W'(report_bus.ping_fired), CNT_W'(want.ping_fired));
        if (report_bus.holding_off !== want.holding_off)
          report_mismatch("holding_off", want.sample_number,
                          CNT_W'(report_bus.holding_off), CNT_W'(want.holding_off));
        if (report_bus.sample_number !== want.sample_number)
          report_mismatch("sample_number", want.sample_number,
                          report_bus.sample_number, want.sample_number);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset offsets and noise levels, rail and bit-pattern samples.
  task automatic test_reset_registers();
    send_sample_set(make_set(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
    send_sample_set(make_set(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    send_sample_set(make_set(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    send_sample_set(make_set(16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0001));
    send_sample_set(make_set(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA));
    send_sample_set(make_set(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555));
    send_sample_set(make_set(16'shFFFF, 16'sh0001, 16'sh8000, 16'sh7FFF));
  endtask

  // Offset rails against opposite sample rails: the difference needs more
  // than 32 bits and a handful of such squares wrap the 64-bit window sum.
  // Junk above bit 31 of the offset writes must be dropped. Noise at both
  // extremes, the top one checks that 20x noise does not overflow.
  task automatic test_register_extremes();
    reg_image_t img;
    img = flat_image(OFS_MIN, NOISE_MAX, NOISE_MAX);
    img[REG_OFS_BASE + 1] = {27'h5A5_A5A5, OFS_MAX};
    img[REG_OFS_BASE + 3] = {27'h7FF_FFFF, OFS_MAX};
    img[REG_NOISE_BASE + 2] = '0;
    load_image(img);
    repeat (6) send_sample_set(make_set(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
    repeat (2) send_sample_set(make_set(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
  endtask

  // Steady tone so the window power is exactly 20x EDGE_NOISE: one notch
  // above must not trigger, equality must, and hold-on is kept once the
  // trigger goes away.
  task automatic test_threshold_edge();
    load_image(flat_image('0, NOISE_MAX, NOISE_MAX));
    repeat (WIN_LEN) send_sample_set(make_set(TONE, TONE, TONE, TONE));
    load_image(flat_image('0, EDGE_NOISE + 1, EDGE_NOISE));
    repeat (4) send_sample_set(make_set(TONE, TONE, TONE, TONE));
    load_image(flat_image('0, EDGE_NOISE, EDGE_NOISE));
    repeat (6) send_sample_set(make_set(TONE, TONE, TONE, TONE));
    load_image(flat_image('0, NOISE_MAX, NOISE_MAX));
    repeat (3) send_sample_set(make_set(TONE, TONE, TONE, TONE));
  endtask

  // Random register settings, each phase at its own signal amplitude.
  task automatic test_random_traffic();
    int amp;
    for (int ph = 0; ph < 8; ph++) begin
      load_image(random_image());
      amp = 1 << $urandom_range(3, 15);
      repeat (40)
        send_sample_set(make_set(random_sample(amp), random_sample(amp),
                                 random_sample(amp), random_sample(amp)));
    end
  endtask

  // Zero noise keeps every sample triggered: build hold-on at full rate and
  // fire, then run on into the hold-off under stalls, where hold-on stays
  // clear and nothing fires.
  task automatic test_ping_and_holdoff();
    int target;
    int sent;
    load_image(flat_image($urandom, '0, '0));
    calm   = 1'b1;
    target = pings_fired + 1;
    sent   = 0;
    while (pings_fired < target && sent < 2 * HOLDON_SAMPLES + 8) begin
      send_sample_set(make_set(sample_t'($urandom), sample_t'($urandom),
                               sample_t'($urandom), sample_t'($urandom)));
      sent++;
    end
    calm = 1'b0;
    repeat (100)
      send_sample_set(make_set(sample_t'($urandom), sample_t'($urandom),
                               sample_t'($urandom), sample_t'($urandom)));
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    sample_bus.valid      = 1'b0;
    sample_bus.sample_ch0 = '0;
    sample_bus.sample_ch1 = '0;
    sample_bus.sample_ch2 = '0;
    sample_bus.sample_ch3 = '0;
    report_bus.ready      = 1'b0;
    calm                  = 1'b0;
    burst_left            = 0;
    rx_mode               = RX_OPEN;
    rx_left               = 0;
    pings_fired           = 0;
    mismatches            = 0;
    reset_detector_model();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_registers();
    test_register_extremes();
    test_threshold_edge();
    test_ping_and_holdoff();
    test_random_traffic();

    // drain, then give the pipe time to show any stray report
    sample_bus.valid <= 1'b0;
    while (detector_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: fails the run if it is still going at the timeout.
  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== multichannel_ping_power_trigger_top.f =====
design/mppt_pkg.sv
design/mppt_sample_if.sv
design/mppt_result_if.sv
design/mppt_ring_mem.sv
design/mppt_power_pipe.sv
design/mppt_trigger_ctrl.sv
design/mppt_out_fifo.sv
design/multichannel_ping_power_trigger_top.sv
verif/multichannel_ping_power_trigger_top_tb.sv
